[hdl/kbed_pkg.sv]
// Shared types and constants for the knob and button event decoder.
// Depends on nothing; imported by knob_button_event_decoder.
`default_nettype none

package kbed_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_CLICK = 2'd1,
    CFG_MIN_CLICK  = 2'd2
  } kbed_cfg_e;

  localparam int unsigned CFG_DATA_BITS = 16;
  typedef logic [CFG_DATA_BITS-1:0] kbed_ms_t;

  localparam kbed_ms_t DEBOUNCE_RESET   = 16'd100;
  localparam kbed_ms_t LONG_CLICK_RESET = 16'd1000;
  localparam kbed_ms_t MIN_CLICK_RESET  = 16'd10;

  // Scroll step codes, two-bit signed
  typedef logic signed [1:0] kbed_step_t;
  localparam kbed_step_t STEP_NONE = 2'sb00;
  localparam kbed_step_t STEP_UP   = 2'sb01;
  localparam kbed_step_t STEP_DOWN = 2'sb11;

  // Stream payload widths (fields padded to whole bytes)
  localparam int unsigned IN_DATA_BITS  = 8;
  localparam int unsigned OUT_DATA_BITS = 8;

endpackage : kbed_pkg

`default_nettype wire

[hdl/knob_button_event_decoder.sv]
// Knob and button event decoder: debounced button click / long click and
// quadrature encoder steps, one input beat per millisecond tick.
// Depends on kbed_pkg.
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid/tready      | tdata: button_level, enc_a, enc_b
//  m_axis   | out | m_axis_tvalid/tready      | tdata: scroll_step, click, long_click
//  cfg      | in  | cfg_valid_i/cfg_ready_o   | cfg_index_i, cfg_data_i
//
// One beat in, one beat out; a beat is taken every cycle unless the output
// stalls, and its result passes the input register, then the result register.
// A single combinational compare stage lies between those registers.
// Reset: tick counter 1, stamps 0, button released, encoder A low, config
// registers at their defaults. A stalled output holds its beat; the input
// register takes one more beat, then input ready drops.
`default_nettype none

module knob_button_event_decoder
  import kbed_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // tdata: [0] button_level, [1] enc_a, [2] enc_b, [7:3] zero
  input  wire logic                     s_axis_tvalid_i,
  output      logic                     s_axis_tready_o,
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata_i,
  // tdata: [1:0] scroll_step, [2] click, [3] long_click, [7:4] zero
  output      logic                     m_axis_tvalid_o,
  input  wire logic                     m_axis_tready_i,
  output      logic [OUT_DATA_BITS-1:0] m_axis_tdata_o,
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  typedef logic [TIME_BITS-1:0] time_t;

  // Configuration
  kbed_ms_t debounce_q, long_click_q, min_click_q;

  // Input register
  logic in_valid_q;
  logic in_level_q, in_a_q, in_b_q;

  // Decoder state; tick_next_q holds the time stamp of the next tick
  time_t tick_next_q, press_q, release_q, handled_q;
  logic  prev_level_q, prev_a_q;

  // Result register
  logic       out_valid_q;
  kbed_step_t step_q, step_d;
  logic       click_q, click_d, long_q, long_d;

  logic  advance;
  time_t now, press_age, release_age, hold_diff, click_diff;
  logic  level_edge, press_take, release_take, pending;

  assign cfg_ready_o = 1'b1;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RESET;
      long_click_q <= LONG_CLICK_RESET;
      min_click_q  <= MIN_CLICK_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEBOUNCE:   debounce_q   <= cfg_data_i;
        CFG_LONG_CLICK: long_click_q <= cfg_data_i;
        CFG_MIN_CLICK:  min_click_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_level_q <= s_axis_tdata_i[0];
      in_a_q     <= s_axis_tdata_i[1];
      in_b_q     <= s_axis_tdata_i[2];
    end
  end

  // Event logic
  assign now         = tick_next_q;
  assign press_age   = now - press_q;
  assign release_age = now - release_q;
  assign hold_diff   = press_age;

  assign level_edge   = in_level_q != prev_level_q;
  assign press_take   = level_edge && !in_level_q && (press_age > time_t'(debounce_q));
  assign release_take = level_edge && in_level_q && (release_age > time_t'(debounce_q));

  // A fresh press stamp equals now, so it is pending but cannot be long yet
  assign pending = press_take ? (now != handled_q) : (press_q != handled_q);

  // With the button up the press stamp is unchanged this tick
  assign click_diff = release_take ? hold_diff : (release_q - press_q);

  always_comb begin
    step_d = STEP_NONE;
    if (in_a_q != prev_a_q) begin
      step_d = (in_a_q != in_b_q) ? STEP_UP : STEP_DOWN;
    end
    long_d  = pending && !in_level_q && !press_take
              && (hold_diff > time_t'(long_click_q));
    click_d = pending && in_level_q && !click_diff[TIME_BITS-1]
              && (click_diff > time_t'(min_click_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_next_q  <= time_t'(1);
      press_q      <= '0;
      release_q    <= '0;
      handled_q    <= '0;
      prev_level_q <= 1'b1;
      prev_a_q     <= 1'b0;
    end else if (advance) begin
      tick_next_q  <= tick_next_q + time_t'(1);
      prev_level_q <= in_level_q;
      prev_a_q     <= in_a_q;
      if (press_take) begin
        press_q <= now;
      end
      if (release_take) begin
        release_q <= now;
      end
      if (long_d || click_d) begin
        handled_q <= press_q;
      end
    end
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      step_q  <= step_d;
      click_q <= click_d;
      long_q  <= long_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_BITS-4){1'b0}}, long_q, click_q, step_q};

  // Checks
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(click_q && long_q))
    else $error("click and long click in the same beat");

  a_step_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (step_q != 2'sb10))
    else $error("invalid scroll step code");

  a_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !press_take && (press_q == handled_q)) |=> (!click_q && !long_q))
    else $error("event without a pending press");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a full output");

endmodule : knob_button_event_decoder

`default_nettype wire
